@@ src/zgfr_pkg.sv @@
// Shared types and constants of the greeting checker and frame receiver.
`default_nettype none
package zgfr_pkg;

  // Result kinds
  localparam logic [1:0] KIND_GREETING = 2'd0;
  localparam logic [1:0] KIND_BODY     = 2'd1;
  localparam logic [1:0] KIND_EMPTY    = 2'd2;
  localparam logic [1:0] KIND_ERROR    = 2'd3;

  // Error causes
  localparam logic [2:0] CAUSE_NONE      = 3'd0;
  localparam logic [2:0] CAUSE_SIGNATURE = 3'd1;
  localparam logic [2:0] CAUSE_VERSION   = 3'd2;
  localparam logic [2:0] CAUSE_MECHANISM = 3'd3;
  localparam logic [2:0] CAUSE_TOO_LONG  = 3'd4;

  // Greeting constants
  localparam logic [7:0] SIG_FIRST = 8'hFF;

  // Frame flag bit positions
  localparam int MORE_BIT = 0;
  localparam int LONG_BIT = 1;
  localparam int CMD_BIT  = 2;

  // Register indexes on the configuration port
  localparam logic REG_MAX_BODY  = 1'b0;
  localparam logic REG_MIN_MAJOR = 1'b1;

  typedef struct packed {
    logic [15:0] max_body_length;
    logic [7:0]  min_major_version;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic        is_command;
    logic        has_more;
    logic        last_byte;
    logic [15:0] frame_length;
    logic [2:0]  error_cause;
  } result_t;

  // Mechanism name "NULL", one byte per position
  function automatic logic [7:0] mech_byte(input logic [1:0] pos);
    logic [7:0] r;
    unique case (pos)
      2'd0:    r = 8'h4E;
      2'd1:    r = 8'h55;
      default: r = 8'h4C;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

@@ src/zgfr_queue.sv @@
// Front byte queue that decouples the receive side from the parser.
`default_nettype none
module zgfr_queue #(
  parameter int DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  logic [7:0] push_data,
  output logic       full,
  input  logic       pop,
  output logic       not_empty,
  output logic [7:0] head_data
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [7:0]    mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full      = (count_r == FULL_CNT);
  assign not_empty = (count_r != '0);
  assign head_data = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  // Advance pointers with wrap at the queue depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the incoming byte
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

@@ src/zgfr_parser.sv @@
// Back end: greeting check, frame deframing and the result register.
`default_nettype none
module zgfr_parser (
  input  logic            clk,
  input  logic            rst_n,
  input  zgfr_pkg::cfg_t  cfg,
  input  logic            byte_valid,
  input  logic [7:0]      byte_data,
  output logic            byte_pop,
  output logic            res_valid,
  output zgfr_pkg::result_t res,
  input  logic            res_ready
);
  import zgfr_pkg::*;

  localparam logic [2:0] PH_GREETING = 3'd0;
  localparam logic [2:0] PH_FLAGS    = 3'd1;
  localparam logic [2:0] PH_LENGTH   = 3'd2;
  localparam logic [2:0] PH_BODY     = 3'd3;
  localparam logic [2:0] PH_DEAD     = 3'd4;

  logic [2:0]  phase_r, phase_nxt;
  logic [5:0]  gidx_r, gidx_nxt;
  logic [2:0]  flags_r, flags_nxt;
  logic [15:0] acc_low_r, acc_low_nxt;
  logic        acc_hi_r, acc_hi_nxt;
  logic [3:0]  len_left_r, len_left_nxt;
  logic [15:0] body_left_r, body_left_nxt;
  logic [7:0]  minor_r, minor_nxt;
  logic        out_valid_r;
  result_t     out_r;
  logic        fire, emit;
  result_t     emit_res;
  logic [15:0] shifted_low;
  logic        shifted_hi;

  assign fire     = byte_valid && (!out_valid_r || res_ready);
  assign byte_pop = fire;
  assign res_valid = out_valid_r;
  assign res       = out_r;

  assign shifted_low = {acc_low_r[7:0], byte_data};
  assign shifted_hi  = acc_hi_r || (acc_low_r[15:8] != 8'd0);

  // Work out the next state and any result for the head byte
  always_comb begin
    phase_nxt     = phase_r;
    gidx_nxt      = gidx_r;
    flags_nxt     = flags_r;
    acc_low_nxt   = acc_low_r;
    acc_hi_nxt    = acc_hi_r;
    len_left_nxt  = len_left_r;
    body_left_nxt = body_left_r;
    minor_nxt     = minor_r;
    emit          = 1'b0;
    emit_res      = '0;
    unique case (phase_r)
      PH_GREETING: begin
        gidx_nxt = gidx_r + 6'd1;
        if ((gidx_r == 6'd0 && byte_data != SIG_FIRST) ||
            (gidx_r == 6'd9 && !byte_data[0])) begin
          emit = 1'b1;
          emit_res.kind = KIND_ERROR;
          emit_res.error_cause = CAUSE_SIGNATURE;
          phase_nxt = PH_DEAD;
        end else if (gidx_r == 6'd10 && byte_data < cfg.min_major_version) begin
          emit = 1'b1;
          emit_res.kind = KIND_ERROR;
          emit_res.error_cause = CAUSE_VERSION;
          phase_nxt = PH_DEAD;
        end else if ((gidx_r >= 6'd12 && gidx_r <= 6'd15 &&
                      byte_data != mech_byte(gidx_r[1:0])) ||
                     (gidx_r >= 6'd16 && gidx_r <= 6'd31 && byte_data != 8'd0)) begin
          emit = 1'b1;
          emit_res.kind = KIND_ERROR;
          emit_res.error_cause = CAUSE_MECHANISM;
          phase_nxt = PH_DEAD;
        end else if (gidx_r == 6'd63) begin
          emit = 1'b1;
          emit_res.kind = KIND_GREETING;
          emit_res.data = minor_r;
          phase_nxt = PH_FLAGS;
        end
        if (gidx_r == 6'd11) begin
          minor_nxt = byte_data;
        end
      end
      PH_FLAGS: begin
        flags_nxt    = byte_data[2:0];
        acc_low_nxt  = '0;
        acc_hi_nxt   = 1'b0;
        len_left_nxt = byte_data[LONG_BIT] ? 4'd8 : 4'd1;
        phase_nxt    = PH_LENGTH;
      end
      PH_LENGTH: begin
        acc_low_nxt  = shifted_low;
        acc_hi_nxt   = shifted_hi;
        len_left_nxt = len_left_r - 4'd1;
        if (len_left_r <= 4'd1) begin
          // Last length byte: check the limit, then empty frame or body
          if (shifted_hi || shifted_low > cfg.max_body_length) begin
            emit = 1'b1;
            emit_res.kind = KIND_ERROR;
            emit_res.error_cause = CAUSE_TOO_LONG;
            phase_nxt = PH_DEAD;
          end else if (shifted_low == 16'd0) begin
            emit = 1'b1;
            emit_res.kind = KIND_EMPTY;
            emit_res.is_command = flags_r[CMD_BIT];
            emit_res.has_more = flags_r[MORE_BIT];
            emit_res.last_byte = 1'b1;
            phase_nxt = PH_FLAGS;
          end else begin
            body_left_nxt = shifted_low;
            phase_nxt = PH_BODY;
          end
        end
      end
      PH_BODY: begin
        body_left_nxt = body_left_r - 16'd1;
        emit = 1'b1;
        emit_res.kind = KIND_BODY;
        emit_res.data = byte_data;
        emit_res.is_command = flags_r[CMD_BIT];
        emit_res.has_more = flags_r[MORE_BIT];
        emit_res.last_byte = (body_left_r <= 16'd1);
        emit_res.frame_length = acc_low_r;
        if (body_left_r <= 16'd1) begin
          phase_nxt = PH_FLAGS;
        end
      end
      default: begin
        // Dead after an error: drop every byte
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_GREETING;
      gidx_r      <= '0;
      flags_r     <= '0;
      acc_low_r   <= '0;
      acc_hi_r    <= 1'b0;
      len_left_r  <= '0;
      body_left_r <= '0;
      minor_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        phase_r     <= phase_nxt;
        gidx_r      <= gidx_nxt;
        flags_r     <= flags_nxt;
        acc_low_r   <= acc_low_nxt;
        acc_hi_r    <= acc_hi_nxt;
        len_left_r  <= len_left_nxt;
        body_left_r <= body_left_nxt;
        minor_r     <= minor_nxt;
      end
      if (fire && emit) begin
        out_valid_r <= 1'b1;
      end else if (res_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (fire && emit) begin
      out_r <= emit_res;
    end
  end

  a_dead_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DEAD) |-> !(fire && emit))
    else $error("result produced after a protocol error");

  a_cause_matches_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_r.kind == KIND_ERROR) == (out_r.error_cause != CAUSE_NONE)))
    else $error("error cause does not match result kind");

  a_body_left: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_BODY) |-> (body_left_r != 16'd0))
    else $error("body phase with no bytes left");

  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.last_byte) |->
      (out_r.kind == KIND_BODY || out_r.kind == KIND_EMPTY))
    else $error("last mark on a result that is not frame data");

endmodule
`default_nettype wire

@@ src/zmtp_greeting_and_frame_receiver_top.sv @@
// Top level: byte stream in, greeting and frame results out, register port.
//
// The in_ channel carries one received byte per request. The block checks
// the 64-byte greeting, reports its acceptance with the minor version, then
// splits the stream into frames and reports every body byte (with flags,
// frame length and a last mark), each empty frame once, and the first
// protocol error once. Bytes that yield no result (most greeting bytes,
// flags and length bytes, everything after an error) produce nothing.
// Throughput is one byte per cycle while no waiting result is stalled by
// out_tready. An accepted byte is written into the queue, and when the
// parser takes it from the queue head its result is registered in the
// result register and presented on out_. The queue holds QUEUE_DEPTH
// bytes, so the input keeps taking bytes for that long while out_tready is
// low; a waiting result is held stable until taken. Reset (rst_n low,
// synchronous) empties the queue, returns the parser to the start of the
// greeting and loads the register defaults: max_body_length 4096,
// min_major_version 3. Registers sit at byte addresses 0 and 4 and take
// effect on the next byte that uses them.
`default_nettype none
module zmtp_greeting_and_frame_receiver_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  // in: rx_byte[7:0]
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,
  // out tdata: data[7:0], is_command[8], has_more[9], frame_length[25:10],
  // error_cause[28:26], zero[31:29]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,
  output logic        out_tlast,
  // out tuser: kind[1:0]
  output logic [1:0]  out_tuser,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import zgfr_pkg::*;

  cfg_t    cfg_r;
  logic    q_full, q_valid, q_pop;
  logic [7:0] q_data;
  logic    res_valid;
  result_t res;
  logic    wr_en;

  // Register file
  assign cfg_pready = 1'b1;
  assign wr_en = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_body_length   <= 16'd4096;
      cfg_r.min_major_version <= 8'd3;
    end else if (wr_en) begin
      unique case (cfg_paddr[2])
        REG_MAX_BODY:  cfg_r.max_body_length   <= cfg_pwdata[15:0];
        REG_MIN_MAJOR: cfg_r.min_major_version <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (cfg_paddr[2])
      REG_MAX_BODY:  cfg_prdata = {16'd0, cfg_r.max_body_length};
      REG_MIN_MAJOR: cfg_prdata = {24'd0, cfg_r.min_major_version};
      default:       cfg_prdata = '0;
    endcase
  end

  zgfr_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_tvalid),
    .push_data (in_tdata),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head_data (q_data)
  );

  assign in_tready = !q_full;

  zgfr_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .byte_valid (q_valid),
    .byte_data  (q_data),
    .byte_pop   (q_pop),
    .res_valid  (res_valid),
    .res        (res),
    .res_ready  (out_tready)
  );

  // Pack the result
  assign out_tvalid = res_valid;
  assign out_tdata  = {3'd0, res.error_cause, res.frame_length, res.has_more,
                       res.is_command, res.data};
  assign out_tlast  = res.last_byte;
  assign out_tuser  = res.kind;

endmodule
`default_nettype wire
